[hw/rtl/matrix_multiply_4x4_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 4x4 matrix multiply unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_4X4_UNIT_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define MM4_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mm4 assertion failed");
// next-cycle implication, checked out of reset
`define MM4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mm4 assertion failed");
`else
`define MM4_ASSERT_IMPLIES(lbl, ante, cons)
`define MM4_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/mm4_pkg.sv]
// ----------------------------------------------------------------------------
// mm4_pkg
// Widths and constants shared by the 4x4 matrix multiply unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mm4_pkg;

  localparam int MATRIX_ORDER = 4;
  localparam int FRAC_BITS    = 16;

  localparam int DATA_W       = 32;
  localparam int ELEM_COUNT   = MATRIX_ORDER * MATRIX_ORDER;
  localparam int ADDR_W       = $clog2(ELEM_COUNT);
  localparam int ORD_W        = $clog2(MATRIX_ORDER);
  localparam int PROD_W       = 2 * DATA_W;
  localparam int ACC_W        = PROD_W + ORD_W + 1;
  localparam int RES_IDX_W    = 4;

  localparam int IN_TDATA_W   = 2 * DATA_W;
  localparam int OUT_FIELD_W  = DATA_W + RES_IDX_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELD_W;
  localparam int OUT_TUSER_W  = 1;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

[hw/rtl/matrix_multiply_4x4_unit.sv]
// After the sixteenth input word is accepted, the first result word passes through
// the store read, product, accumulator and output registers; later results follow
// as each further sum completes, when the output is not stalled. A batch loads
// sixteen words, then runs 64 multiply-accumulates on the single shared 32x32 multiplier.
// Reset: rst_n (synchronous, active low) clears the load count, sequencer and valid
// flags; the element stores are not cleared and are always written before being read.
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_multiply_4x4_unit_macros.svh"

// ----------------------------------------------------------------------------
// matrix_multiply_4x4_unit
// Loads A and B element by element, then runs one shared MAC over all sums.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // slave side
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [mm4_pkg::IN_TDATA_W-1:0]   in_tdata,   // a_value, b_value
  // master side
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [mm4_pkg::OUT_TDATA_W-1:0]       out_tdata,  // product_value, result_index
  output logic [mm4_pkg::OUT_TUSER_W-1:0]       out_tuser,  // saturated
  output logic                                  out_tlast   // last_result
);
  import mm4_pkg::*;

  localparam logic S_LOAD = 1'b0;
  localparam logic S_RUN  = 1'b1;

  localparam logic [ORD_W-1:0]  ORD_LAST  = ORD_W'(MATRIX_ORDER - 1);
  localparam logic [ADDR_W-1:0] ELEM_LAST = ADDR_W'(ELEM_COUNT - 1);

  logic state_r, state_nxt;
  logic [ADDR_W-1:0] load_cnt_r, load_cnt_nxt;
  logic [ORD_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  logic [DATA_W-1:0] mem_a [ELEM_COUNT];
  logic [DATA_W-1:0] mem_b [ELEM_COUNT];

  logic              in_acc;
  logic              adv;
  logic              issue;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, res_idx;

  // stage 1: registered store reads
  logic signed [DATA_W-1:0] rd_a_r, rd_b_r;
  logic                     s1_vld_r, s1_first_r, s1_lastk_r, s1_final_r;
  logic [ADDR_W-1:0]        s1_idx_r;
  // stage 2: product
  logic signed [PROD_W-1:0] prod_r;
  logic                     s2_vld_r, s2_first_r, s2_lastk_r, s2_final_r;
  logic [ADDR_W-1:0]        s2_idx_r;
  // stage 3: accumulator
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     s3_done_r, s3_final_r;
  logic [ADDR_W-1:0]        s3_idx_r;
  // saturation
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-DATA_W:0]    hi_bits;
  logic                     sat;
  logic [DATA_W-1:0]        sat_val;
  // output register
  logic                     out_vld_r;
  logic [DATA_W-1:0]        out_val_r;
  logic [RES_IDX_W-1:0]     out_idx_r;
  logic                     out_sat_r, out_last_r;

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  // the whole compute pipeline moves only when the output slot can take a word
  assign adv       = !out_vld_r || out_tready;
  assign issue     = (state_r == S_RUN) && adv;

  assign rd_addr_a = ADDR_W'(ADDR_W'(k_r) * ADDR_W'(MATRIX_ORDER) + ADDR_W'(j_r));
  assign rd_addr_b = ADDR_W'(ADDR_W'(i_r) * ADDR_W'(MATRIX_ORDER) + ADDR_W'(k_r));
  assign res_idx   = ADDR_W'(ADDR_W'(i_r) * ADDR_W'(MATRIX_ORDER) + ADDR_W'(j_r));

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (load_cnt_r == ELEM_LAST) begin
            load_cnt_nxt = '0;
            state_nxt    = S_RUN;
            i_nxt        = '0;
            j_nxt        = '0;
            k_nxt        = '0;
          end else begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
        end
      end
      S_RUN: begin
        if (adv) begin
          if (k_r != ORD_LAST) begin
            k_nxt = k_r + 1'b1;
          end else begin
            k_nxt = '0;
            if (j_r != ORD_LAST) begin
              j_nxt = j_r + 1'b1;
            end else begin
              j_nxt = '0;
              if (i_r != ORD_LAST) begin
                i_nxt = i_r + 1'b1;
              end else begin
                // all reads issued: stores are free for the next batch
                i_nxt     = '0;
                state_nxt = S_LOAD;
              end
            end
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      load_cnt_r <= '0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      k_r        <= k_nxt;
    end
  end

  // element stores
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_a[load_cnt_r] <= in_tdata[DATA_W-1:0];
      mem_b[load_cnt_r] <= in_tdata[2*DATA_W-1:DATA_W];
    end
    if (adv) begin
      rd_a_r <= mem_a[rd_addr_a];
      rd_b_r <= mem_b[rd_addr_b];
    end
  end

  // pipeline tags and datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first_r <= (k_r == '0);
      s1_lastk_r <= (k_r == ORD_LAST);
      s1_final_r <= (res_idx == ELEM_LAST);
      s1_idx_r   <= res_idx;
      prod_r     <= rd_a_r * rd_b_r;
      s2_first_r <= s1_first_r;
      s2_lastk_r <= s1_lastk_r;
      s2_final_r <= s1_final_r;
      s2_idx_r   <= s1_idx_r;
      acc_r      <= acc_nxt;
      s3_final_r <= s2_final_r;
      s3_idx_r   <= s2_idx_r;
      out_val_r  <= sat_val;
      out_idx_r  <= RES_IDX_W'(s3_idx_r);
      out_sat_r  <= sat;
      out_last_r <= s3_final_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_done_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= issue;
      s2_vld_r  <= s1_vld_r;
      s3_done_r <= s2_vld_r && s2_lastk_r;
      out_vld_r <= s3_done_r;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (s2_vld_r) begin
      if (s2_first_r) begin
        acc_nxt = ACC_W'(prod_r);
      end else begin
        acc_nxt = acc_r + ACC_W'(prod_r);
      end
    end
  end

  // floor shift, then clip to 32 bits
  assign shifted = acc_r >>> FRAC_BITS;
  assign hi_bits = shifted[ACC_W-1:DATA_W-1];
  assign sat     = !((&hi_bits) || !(|hi_bits));

  always_comb begin
    if (!sat) begin
      sat_val = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val = SAT_MAX;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_idx_r, out_val_r};
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

  `MM4_ASSERT_NEXT(a_done_to_out, s3_done_r && adv, out_vld_r)
  `MM4_ASSERT_IMPLIES(a_last_index, out_vld_r && out_last_r,
                      out_idx_r == RES_IDX_W'(ELEM_COUNT - 1))
  `MM4_ASSERT_NEXT(a_batch_start, in_acc && (load_cnt_r == ELEM_LAST),
                   (state_r == S_RUN) && (k_r == '0) && (i_r == '0) && (j_r == '0))
  `MM4_ASSERT_IMPLIES(a_sat_value, out_vld_r && out_sat_r,
                      (out_val_r == SAT_MAX) || (out_val_r == SAT_MIN))

endmodule

`default_nettype wire

[bench/matrix_multiply_4x4_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_unit_tb
// Streams batches of sixteen A/B element pairs into the unit. A model of the
// 4x4 Q16.16 product with floor shift and saturation runs alongside it. Each
// product word is checked against the oldest pending prediction, with random
// stalls on both sides, a long output hold and a full-rate stretch.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_unit_tb;
  import mm4_pkg::*;

  localparam int IDLE_PCT    = 27;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [DATA_W-1:0]    product;
    logic [RES_IDX_W-1:0] index;
    logic                 sat;
    logic                 last;
  } product_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;   // a_value, b_value
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // product_value, result_index
  logic [OUT_TUSER_W-1:0] out_tuser;        // saturated
  logic                   out_tlast;        // last_result

  // product model state
  logic signed [DATA_W-1:0] a_store [ELEM_COUNT];
  logic signed [DATA_W-1:0] b_store [ELEM_COUNT];
  int unsigned              fill_idx = 0;
  product_t                 pending_products[$];
  product_t                 want_product;

  int err_count    = 0;
  int stall_cycles = 0;
  int hold_request = 0;
  int hold_left    = 0;
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;

  matrix_multiply_4x4_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic product_t predict_element(input int i, input int j);
    logic signed [71:0] acc;
    longint             scaled;
    product_t           r;
    acc = '0;
    for (int k = 0; k < MATRIX_ORDER; k++)
      acc += longint'(a_store[k*MATRIX_ORDER+j]) * longint'(b_store[i*MATRIX_ORDER+k]);
    // arithmetic shift floors toward minus infinity
    scaled = longint'(acc >>> FRAC_BITS);
    if (scaled > longint'(SAT_MAX)) begin
      r.product = SAT_MAX;
      r.sat     = 1'b1;
    end else if (scaled < longint'(SAT_MIN)) begin
      r.product = SAT_MIN;
      r.sat     = 1'b1;
    end else begin
      r.product = scaled[DATA_W-1:0];
      r.sat     = 1'b0;
    end
    r.index = RES_IDX_W'(i*MATRIX_ORDER + j);
    r.last  = (i*MATRIX_ORDER + j == ELEM_COUNT - 1);
    return r;
  endfunction

  task automatic absorb_element(input logic [DATA_W-1:0] a_val, input logic [DATA_W-1:0] b_val);
    a_store[fill_idx] = a_val;
    b_store[fill_idx] = b_val;
    if (fill_idx == ELEM_COUNT - 1) begin
      fill_idx = 0;
      for (int i = 0; i < MATRIX_ORDER; i++)
        for (int j = 0; j < MATRIX_ORDER; j++)
          pending_products.push_back(predict_element(i, j));
    end else begin
      fill_idx++;
    end
  endtask

  // Offer one word, wait for the handshake, then update the model.
  task automatic send_word(input logic [DATA_W-1:0] a_val, input logic [DATA_W-1:0] b_val);
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b_val, a_val};
    do @(posedge clk); while (!in_tready);
    absorb_element(a_val, b_val);
  endtask

  // Drop valid and hold until every predicted product has been seen.
  task automatic wait_for_products();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_products.size() != 0);
  endtask

  function automatic logic [DATA_W-1:0] pick_element(input bit wide);
    int unsigned sel;
    sel = $urandom_range(7);
    if (wide || sel == 0)
      return $urandom;
    if (sel == 1) begin
      case ($urandom_range(4))
        0:       return SAT_MAX;
        1:       return SAT_MIN;
        2:       return '0;
        3:       return '1;
        default: return 32'h0001_0000;
      endcase
    end
    // a few units either side of zero in Q16.16
    return DATA_W'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
  endfunction

  task automatic send_random_batch(input bit wide);
    for (int n = 0; n < ELEM_COUNT; n++)
      send_word(pick_element(wide), pick_element(wide));
  endtask

  // Saturation both ways, floor of small negatives, and unity scaling.
  task automatic test_extremes();
    logic signed [DATA_W-1:0] col_a [MATRIX_ORDER];
    logic signed [DATA_W-1:0] row_b [MATRIX_ORDER];
    logic signed [DATA_W-1:0] mix_b [MATRIX_ORDER];
    col_a = '{SAT_MAX, SAT_MIN, -32'sd1, 32'sh0001_0000};
    row_b = '{SAT_MAX, SAT_MIN, 32'sd1, 32'sd0};
    mix_b = '{32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000, 32'sd0};
    for (int n = 0; n < ELEM_COUNT; n++)
      send_word(col_a[n % MATRIX_ORDER],
                (n / MATRIX_ORDER == MATRIX_ORDER - 1) ? mix_b[n % MATRIX_ORDER]
                                                       : row_b[n / MATRIX_ORDER]);
  endtask

  task automatic test_random_batches(input int batches);
    for (int b = 0; b < batches; b++)
      send_random_batch($urandom_range(3) == 0);
  endtask

  // Hold the output long enough that the unit must stall its input.
  task automatic test_output_hold();
    hold_request = HOLD_CYCLES;
    send_random_batch(1'b0);
    send_random_batch(1'b1);
    wait_for_products();
  endtask

  task automatic test_full_rate();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_random_batch(1'b0);
    send_random_batch(1'b0);
    wait_for_products();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // receiver: random back-pressure plus the occasional long hold
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (sink_idle_en) begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_products.size() == 0) begin
        $error("product word with nothing pending: index %0d value %h",
               out_tdata[DATA_W +: RES_IDX_W], out_tdata[DATA_W-1:0]);
        err_count++;
      end else begin
        want_product = pending_products.pop_front();
        if (out_tdata[DATA_W-1:0] !== want_product.product) begin
          $error("product_value: expected %h, got %h",
                 want_product.product, out_tdata[DATA_W-1:0]);
          err_count++;
        end
        if (out_tdata[DATA_W +: RES_IDX_W] !== want_product.index) begin
          $error("result_index: expected %0d, got %0d",
                 want_product.index, out_tdata[DATA_W +: RES_IDX_W]);
          err_count++;
        end
        if (out_tuser[0] !== want_product.sat) begin
          $error("saturated: expected %b, got %b", want_product.sat, out_tuser[0]);
          err_count++;
        end
        if (out_tlast !== want_product.last) begin
          $error("last_result: expected %b, got %b", want_product.last, out_tlast);
          err_count++;
        end
      end
    end
  end

  // end the run if neither side moves a word for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random_batches(10);
    test_output_hold();
    test_full_rate();
    wait_for_products();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
